@@ rtl/tone_melody_sequencer_defines.svh @@
// Assertion helpers; every user has ports named clock and reset.
`ifndef TONE_MELODY_SEQUENCER_DEFINES_SVH
`define TONE_MELODY_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define TMS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tms_pkg.sv @@
package tms_pkg;

   localparam int MELODY_DEPTH_DEFAULT = 64;

   // raw request codes on req_type
   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_BEEP    = 3'd1;
   localparam logic [2:0] REQ_WRITE   = 3'd2;
   localparam logic [2:0] REQ_START   = 3'd3;
   localparam logic [2:0] REQ_STOP    = 3'd4;
   localparam logic [2:0] REQ_TONE    = 3'd5;
   localparam logic [2:0] REQ_SILENCE = 3'd6;
   localparam logic [2:0] REQ_UNUSED  = 3'd7;

   // csr register indexes
   localparam logic CSR_BEEP_LENGTH = 1'b0;
   localparam logic CSR_BEEP_FREQ   = 1'b1;

   localparam logic [7:0]  BEEP_LENGTH_RESET = 8'd3;
   localparam logic [14:0] BEEP_FREQ_RESET   = 15'd1000;

   // PIT input clock, dividend of every tone divisor
   localparam int          DIV_BITS  = 21;
   localparam logic [20:0] PIT_CLOCK = 21'd1193180;

   // classified operations handed from front to back
   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_BEEP    = 3'd1,
      OP_WRITE   = 3'd2,
      OP_START   = 3'd3,
      OP_STOP    = 3'd4,
      OP_TONE    = 3'd5,
      OP_SILENCE = 3'd6,
      OP_NOP     = 3'd7
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [5:0]  slot;
      logic [14:0] freq;
      logic [15:0] ticks;
      logic [6:0]  len;
      logic        len_over;   // length above table depth, saturate
   } cmd_type;

   typedef struct packed {
      logic [14:0] freq;
      logic [15:0] ticks;
   } note_type;

   typedef struct packed {
      logic        start;
      logic [14:0] freq;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/tms_front.sv @@
module tms_front #(
   parameter int MELODY_DEPTH = tms_pkg::MELODY_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [2:0]       req_type,
   input  logic [5:0]       req_note_slot,
   input  logic [14:0]      req_note_freq,
   input  logic [15:0]      req_note_ticks,
   input  logic [6:0]       req_melody_length,
   output logic             cmd_valid,
   output tms_pkg::cmd_type cmd,
   input  logic             cmd_pop
);

   tms_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   tms_pkg::cmd_type dec;
   logic             push_ok;
   logic             pop_ok;

   always_comb begin
      dec.slot     = req_note_slot;
      dec.freq     = req_note_freq;
      dec.ticks    = req_note_ticks;
      dec.len      = req_melody_length;
      dec.len_over = int'(req_melody_length) > MELODY_DEPTH;
      unique case (req_type)
         tms_pkg::REQ_TICK:    dec.op = tms_pkg::OP_TICK;
         tms_pkg::REQ_BEEP:    dec.op = tms_pkg::OP_BEEP;
         tms_pkg::REQ_WRITE:   dec.op = (int'(req_note_slot) < MELODY_DEPTH) ?
                                        tms_pkg::OP_WRITE : tms_pkg::OP_NOP;
         tms_pkg::REQ_START:   dec.op = (req_melody_length != 7'd0) ?
                                        tms_pkg::OP_START : tms_pkg::OP_NOP;
         tms_pkg::REQ_STOP:    dec.op = tms_pkg::OP_STOP;
         tms_pkg::REQ_TONE:    dec.op = tms_pkg::OP_TONE;
         tms_pkg::REQ_SILENCE: dec.op = tms_pkg::OP_SILENCE;
         tms_pkg::REQ_UNUSED:  dec.op = tms_pkg::OP_NOP;
         default:              dec.op = tms_pkg::OP_NOP;
      endcase
   end

   assign req_full  = cnt_ff == 2'd2;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

@@ rtl/tms_div.sv @@
// Restoring divider: PIT_CLOCK / freq, one quotient bit per cycle.
module tms_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tms_pkg::div_req_type div_req,
   output tms_pkg::div_rsp_type div_rsp
);

   localparam int CW = $clog2(tms_pkg::DIV_BITS);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [14:0]                  dv_ff, dv_in;
   logic [14:0]                  rem_ff, rem_in;
   logic [tms_pkg::DIV_BITS-1:0] quo_ff, quo_in;
   logic [15:0]                  trial;
   logic                         ge;

   // quo_ff shifts dividend bits out at the top and quotient bits in below
   assign trial = {rem_ff, quo_ff[tms_pkg::DIV_BITS-1]};
   assign ge    = trial >= {1'b0, dv_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dv_in   = dv_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dv_in   = div_req.freq;
         rem_in  = '0;
         quo_in  = tms_pkg::PIT_CLOCK;
      end else if (busy_ff) begin
         rem_in = ge ? 15'(trial - {1'b0, dv_ff}) : trial[14:0];
         quo_in = {quo_ff[tms_pkg::DIV_BITS-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(tms_pkg::DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dv_ff  <= dv_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[15:0];

endmodule

@@ rtl/tms_back.sv @@
`include "tone_melody_sequencer_defines.svh"

module tms_back #(
   parameter int MELODY_DEPTH = tms_pkg::MELODY_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [14:0]          csr_wdata,
   input  logic                 cmd_valid,
   input  tms_pkg::cmd_type     cmd,
   output logic                 cmd_pop,
   output tms_pkg::div_req_type div_req,
   input  tms_pkg::div_rsp_type div_rsp,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic                 rsp_speaker_on,
   output logic [15:0]          rsp_tone_divisor,
   output logic                 rsp_melody_playing,
   output logic                 rsp_beep_active
);

   localparam int PW = $clog2(MELODY_DEPTH + 1);
   localparam int AW = (MELODY_DEPTH > 1) ? $clog2(MELODY_DEPTH) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        beep_len_ff, beep_len_in;
   logic [14:0]       beep_freq_ff, beep_freq_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [PW-1:0]     notes_ff, notes_in;
   logic [15:0]       ticks_ff, ticks_in;
   logic              playing_ff, playing_in;
   logic [7:0]        beep_cnt_ff, beep_cnt_in;
   logic              gate_ff, gate_in;
   logic [15:0]       divisor_ff, divisor_in;
   logic              load_ticks_ff, load_ticks_in;
   logic              rest_off_ff, rest_off_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_gate_ff, out_playing_ff, out_beep_ff;
   logic [15:0]       out_divisor_ff;
   logic              out_load;
   logic [PW-1:0]     pos_nx;
   logic [AW-1:0]     rd_addr;
   logic              mem_we;
   tms_pkg::note_type mem [MELODY_DEPTH];
   tms_pkg::note_type rd_data_ff;

   assign pos_nx = pos_ff + PW'(1);
   assign mem_we = (state_ff == ST_IDLE) && cmd_valid && (cmd.op == tms_pkg::OP_WRITE);
   assign out_load = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_pop);
   assign cmd_pop  = out_load;

   always_comb begin
      beep_len_in  = beep_len_ff;
      beep_freq_in = beep_freq_ff;
      if (csr_we) begin
         unique case (csr_index)
            tms_pkg::CSR_BEEP_LENGTH: beep_len_in  = csr_wdata[7:0];
            tms_pkg::CSR_BEEP_FREQ:   beep_freq_in = csr_wdata;
            default:                  beep_len_in  = beep_len_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      notes_in      = notes_ff;
      ticks_in      = ticks_ff;
      playing_in    = playing_ff;
      beep_cnt_in   = beep_cnt_ff;
      gate_in       = gate_ff;
      divisor_in    = divisor_ff;
      load_ticks_in = load_ticks_ff;
      rest_off_in   = rest_off_ff;
      div_req.start = 1'b0;
      div_req.freq  = cmd.freq;
      rd_addr       = pos_nx[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_EMIT;
               unique case (cmd.op)
                  tms_pkg::OP_TICK: begin
                     if (beep_cnt_ff != 8'd0) begin
                        beep_cnt_in = beep_cnt_ff - 8'd1;
                        rd_addr     = pos_ff[AW-1:0];
                        if (beep_cnt_ff == 8'd1) begin
                           if (!playing_ff) begin
                              gate_in = 1'b0;
                           end else if (pos_ff < notes_ff) begin
                              // resume the paused note
                              load_ticks_in = 1'b0;
                              rest_off_in   = 1'b1;
                              state_in      = ST_READ;
                           end
                        end
                     end else if (playing_ff) begin
                        if (ticks_ff != 16'd0) begin
                           ticks_in = ticks_ff - 16'd1;
                        end else begin
                           pos_in = pos_nx;
                           if (pos_nx >= notes_ff) begin
                              playing_in = 1'b0;
                              gate_in    = 1'b0;
                              notes_in   = '0;
                           end else begin
                              load_ticks_in = 1'b1;
                              rest_off_in   = 1'b1;
                              state_in      = ST_READ;
                           end
                        end
                     end
                  end
                  tms_pkg::OP_BEEP: begin
                     beep_cnt_in  = beep_len_ff;
                     div_req.freq = beep_freq_ff;
                     if (beep_freq_ff != 15'd0) begin
                        div_req.start = 1'b1;
                        state_in      = ST_DIV;
                     end
                  end
                  tms_pkg::OP_START: begin
                     notes_in      = cmd.len_over ? PW'(MELODY_DEPTH) : PW'(cmd.len);
                     pos_in        = '0;
                     playing_in    = 1'b1;
                     rd_addr       = '0;
                     load_ticks_in = 1'b1;
                     rest_off_in   = 1'b0;   // first note of a start keeps the gate on a rest
                     state_in      = ST_READ;
                  end
                  tms_pkg::OP_STOP: begin
                     playing_in = 1'b0;
                     gate_in    = 1'b0;
                     notes_in   = '0;
                  end
                  tms_pkg::OP_TONE: begin
                     if (cmd.freq != 15'd0) begin
                        div_req.start = 1'b1;
                        state_in      = ST_DIV;
                     end
                  end
                  tms_pkg::OP_SILENCE: gate_in = 1'b0;
                  tms_pkg::OP_WRITE:   state_in = ST_EMIT;
                  tms_pkg::OP_NOP:     state_in = ST_EMIT;
                  default:             state_in = ST_EMIT;
               endcase
            end
         end
         ST_READ: begin
            div_req.freq = rd_data_ff.freq;
            if (load_ticks_ff) begin
               ticks_in = rd_data_ff.ticks;
            end
            if (rd_data_ff.freq == 15'd0) begin
               if (rest_off_ff) begin
                  gate_in = 1'b0;
               end
               state_in = ST_EMIT;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               divisor_in = div_rsp.quotient;
               gate_in    = 1'b1;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         beep_len_ff  <= tms_pkg::BEEP_LENGTH_RESET;
         beep_freq_ff <= tms_pkg::BEEP_FREQ_RESET;
         pos_ff       <= '0;
         notes_ff     <= '0;
         ticks_ff     <= '0;
         playing_ff   <= 1'b0;
         beep_cnt_ff  <= '0;
         gate_ff      <= 1'b0;
         divisor_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         beep_len_ff  <= beep_len_in;
         beep_freq_ff <= beep_freq_in;
         pos_ff       <= pos_in;
         notes_ff     <= notes_in;
         ticks_ff     <= ticks_in;
         playing_ff   <= playing_in;
         beep_cnt_ff  <= beep_cnt_in;
         gate_ff      <= gate_in;
         divisor_ff   <= divisor_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      load_ticks_ff <= load_ticks_in;
      rest_off_ff   <= rest_off_in;
      if (out_load) begin
         out_gate_ff    <= gate_ff;
         out_divisor_ff <= divisor_ff;
         out_playing_ff <= playing_ff;
         out_beep_ff    <= beep_cnt_ff != 8'd0;
      end
   end

   // note table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(cmd.slot)] <= '{freq: cmd.freq, ticks: cmd.ticks};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_speaker_on     = out_gate_ff;
   assign rsp_tone_divisor   = out_divisor_ff;
   assign rsp_melody_playing = out_playing_ff;
   assign rsp_beep_active    = out_beep_ff;

   `TMS_ASSERT_NEXT(a_div_start_waits, div_req.start, state_ff == ST_DIV, "divider started outside DIV")
   `TMS_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_ff == ST_DIV, "divider done unexpected")
   `TMS_ASSERT_NEXT(a_emit_fills_out, out_load, out_valid_ff && state_ff == ST_IDLE, "emit lost")
   `TMS_ASSERT_NOW(a_pos_in_range, playing_ff, pos_ff < notes_ff, "note position past melody end")

endmodule

@@ rtl/tone_melody_sequencer.sv @@
// Channel  Ports                                  Handshake
// req      req_type, req_note_slot/freq/ticks,    accepted when req_push && !req_full
//          req_melody_length
// rsp      rsp_speaker_on, rsp_tone_divisor,      taken when rsp_pop && !rsp_empty
//          rsp_melody_playing, rsp_beep_active
// csr      csr_index, csr_wdata                   written when csr_we
//
// One item at a time in the back end: IDLE, then READ for a note-table lookup and
// DIV when a tone divisor is computed (one bit per cycle in the shared divider),
// then EMIT.
// A two-entry command queue takes items while the back end works; the result
// register holds one item, and a full result register stalls the back end.
// Synchronous active-high reset; the note table is not cleared.
module tone_melody_sequencer #(
   parameter int MELODY_DEPTH = tms_pkg::MELODY_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_type,
   input  logic [5:0]  req_note_slot,
   input  logic [14:0] req_note_freq,
   input  logic [15:0] req_note_ticks,
   input  logic [6:0]  req_melody_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_speaker_on,
   output logic [15:0] rsp_tone_divisor,
   output logic        rsp_melody_playing,
   output logic        rsp_beep_active,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [14:0] csr_wdata
);

   logic                 cmd_valid;
   logic                 cmd_pop;
   tms_pkg::cmd_type     cmd;
   tms_pkg::div_req_type div_req;
   tms_pkg::div_rsp_type div_rsp;

   tms_front #(.MELODY_DEPTH(MELODY_DEPTH)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_type          (req_type),
      .req_note_slot     (req_note_slot),
      .req_note_freq     (req_note_freq),
      .req_note_ticks    (req_note_ticks),
      .req_melody_length (req_melody_length),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   tms_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   tms_back #(.MELODY_DEPTH(MELODY_DEPTH)) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop),
      .div_req            (div_req),
      .div_rsp            (div_rsp),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_speaker_on     (rsp_speaker_on),
      .rsp_tone_divisor   (rsp_tone_divisor),
      .rsp_melody_playing (rsp_melody_playing),
      .rsp_beep_active    (rsp_beep_active)
   );

endmodule

@@ sim/tb_tone_melody_sequencer.sv @@
`timescale 1ns / 1ps

module tb_tone_melody_sequencer;

   localparam int NOTE_SLOTS = 64;
   localparam int PIT_HZ     = 1193180;
   localparam int RAND_ITEMS = 500;
   localparam int PHASES     = 6;

   typedef struct {
      logic [2:0]  kind;
      logic [5:0]  slot;
      logic [14:0] freq;
      logic [15:0] ticks;
      logic [6:0]  len;
   } tone_req_type;

   typedef struct {
      logic        speaker_on;
      logic [15:0] divisor;
      logic        playing;
      logic        beeping;
   } speaker_state_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [2:0]  req_type = tms_pkg::REQ_UNUSED;
   logic [5:0]  req_note_slot = '0;
   logic [14:0] req_note_freq = '0;
   logic [15:0] req_note_ticks = '0;
   logic [6:0]  req_melody_length = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_speaker_on;
   logic [15:0] rsp_tone_divisor;
   logic        rsp_melody_playing;
   logic        rsp_beep_active;
   logic        csr_we = 1'b0;
   logic        csr_index = tms_pkg::CSR_BEEP_LENGTH;
   logic [14:0] csr_wdata = '0;

   tone_melody_sequencer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_type           (req_type),
      .req_note_slot      (req_note_slot),
      .req_note_freq      (req_note_freq),
      .req_note_ticks     (req_note_ticks),
      .req_melody_length  (req_melody_length),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_speaker_on     (rsp_speaker_on),
      .rsp_tone_divisor   (rsp_tone_divisor),
      .rsp_melody_playing (rsp_melody_playing),
      .rsp_beep_active    (rsp_beep_active),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ---------------- sequencer state mirror ----------------
   int unsigned note_freq_mem [NOTE_SLOTS];
   int unsigned note_ticks_mem [NOTE_SLOTS];
   int unsigned cur_note;
   int unsigned melody_notes;
   int unsigned ticks_to_go;
   bit          melody_on;
   int unsigned beep_left;
   bit          gate;
   logic [15:0] divisor;
   int unsigned beep_len_cfg;
   int unsigned beep_freq_cfg;

   tone_req_type      pending_requests [$];
   speaker_state_type expected_speaker [$];
   bit                slot_written [NOTE_SLOTS];
   int                mismatch_count;
   int                items_made;

   // driver state
   tone_req_type cur;
   bit           holding = 1'b0;
   int           burst_left = 1;
   int           gap_left = 0;

   function automatic void sound_tone(int unsigned f);
      if (f != 0) begin
         divisor = 16'((PIT_HZ / f) & 16'hFFFF);
         gate    = 1'b1;
      end
   endfunction

   function automatic void sound_note(int unsigned pos);
      if (note_freq_mem[pos] == 0)
         gate = 1'b0;
      else
         sound_tone(note_freq_mem[pos]);
   endfunction

   function automatic void finish_melody();
      melody_on    = 1'b0;
      gate         = 1'b0;
      melody_notes = 0;
   endfunction

   function automatic void count_tick();
      if (beep_left > 0) begin
         beep_left--;
         if (beep_left == 0) begin
            if (!melody_on)
               gate = 1'b0;
            else if (cur_note < melody_notes)
               sound_note(cur_note);   // resume paused note, rest gates off
         end
      end else if (melody_on) begin
         if (ticks_to_go > 0) begin
            ticks_to_go--;
         end else begin
            cur_note++;
            if (cur_note >= melody_notes) begin
               finish_melody();
            end else begin
               sound_note(cur_note);
               ticks_to_go = note_ticks_mem[cur_note];
            end
         end
      end
   endfunction

   function automatic speaker_state_type sequencer_step(tone_req_type r);
      speaker_state_type s;
      int unsigned       n;
      case (r.kind)
         tms_pkg::REQ_TICK: count_tick();
         tms_pkg::REQ_BEEP: begin
            sound_tone(beep_freq_cfg);
            beep_left = beep_len_cfg;
         end
         tms_pkg::REQ_WRITE: begin
            note_freq_mem[r.slot]  = r.freq;
            note_ticks_mem[r.slot] = r.ticks;
         end
         tms_pkg::REQ_START: begin
            if (r.len != 0) begin
               n = (r.len > NOTE_SLOTS) ? NOTE_SLOTS : r.len;
               melody_notes = n;
               cur_note     = 0;
               sound_tone(note_freq_mem[0]);
               ticks_to_go  = note_ticks_mem[0];
               melody_on    = 1'b1;
            end
         end
         tms_pkg::REQ_STOP:    finish_melody();
         tms_pkg::REQ_TONE:    sound_tone(r.freq);
         tms_pkg::REQ_SILENCE: gate = 1'b0;
         default: ;
      endcase
      s.speaker_on = gate;
      s.divisor    = divisor;
      s.playing    = melody_on;
      s.beeping    = (beep_left != 0);
      return s;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic logic [14:0] rand_freq();
      case ($urandom_range(0, 4))
         0:       return 15'd0;
         1:       return 15'($urandom_range(1, 20));
         2:       return 15'($urandom);
         default: return 15'($urandom_range(1, 20000));
      endcase
   endfunction

   function automatic logic [15:0] rand_ticks();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return 16'($urandom_range(0, 3));
      else if (r < 95)
         return 16'($urandom_range(4, 10));
      return 16'($urandom);
   endfunction

   function automatic int written_prefix();
      int p;
      p = 0;
      while (p < NOTE_SLOTS && slot_written[p])
         p++;
      return p;
   endfunction

   // melody length that only reaches written slots
   function automatic logic [6:0] pick_len();
      int p;
      p = written_prefix();
      if (p == 0)
         return 7'd0;
      if (p < NOTE_SLOTS)
         return 7'($urandom_range(1, (p > 8) ? 8 : p));
      case ($urandom_range(0, 19))
         0, 1, 2:       return 7'($urandom_range(65, 127));
         3, 4, 5, 6, 7: return 7'($urandom_range(1, 64));
         8:             return 7'd0;
         default:       return 7'($urandom_range(1, 8));
      endcase
   endfunction

   task automatic queue_req(logic [2:0] kind, logic [5:0] slot, logic [14:0] freq,
                            logic [15:0] ticks, logic [6:0] len);
      tone_req_type r;
      r.kind  = kind;
      r.slot  = slot;
      r.freq  = freq;
      r.ticks = ticks;
      r.len   = len;
      pending_requests.push_back(r);
      if (kind == tms_pkg::REQ_WRITE)
         slot_written[slot] = 1'b1;
      items_made++;
   endtask

   // unused fields carry random bits
   task automatic queue_op(logic [2:0] kind);
      queue_req(kind, 6'($urandom), rand_freq(), rand_ticks(),
                (kind == tms_pkg::REQ_START) ? pick_len() : 7'($urandom));
   endtask

   task automatic queue_melody_run();
      int r;
      repeat ($urandom_range(0, 4))
         queue_op(tms_pkg::REQ_WRITE);
      queue_op(tms_pkg::REQ_START);
      repeat ($urandom_range(5, 40)) begin
         r = $urandom_range(0, 99);
         if (r < 80)      queue_op(tms_pkg::REQ_TICK);
         else if (r < 88) queue_op(tms_pkg::REQ_BEEP);
         else if (r < 92) queue_op(tms_pkg::REQ_TONE);
         else if (r < 95) queue_op(tms_pkg::REQ_SILENCE);
         else if (r < 97) queue_op(tms_pkg::REQ_STOP);
         else             queue_op(tms_pkg::REQ_WRITE);
      end
   endtask

   task automatic write_csr(logic idx, logic [14:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == tms_pkg::CSR_BEEP_LENGTH)
         beep_len_cfg = value[7:0];
      else
         beep_freq_cfg = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || holding || expected_speaker.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic note_mismatch(string what, int got, int want);
      $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // ---------------- request driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         holding = 1'b0;
      end else begin
         if (req_push && !req_full) begin
            expected_speaker.push_back(sequencer_step(cur));
            holding = 1'b0;
         end
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0) begin
               cur = pending_requests.pop_front();
               holding = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                            : $urandom_range(1, 12);
                  case ($urandom_range(0, 3))
                     0:       gap_left = 0;
                     1:       gap_left = $urandom_range(1, 3);
                     2:       gap_left = $urandom_range(4, 12);
                     default: gap_left = $urandom_range(20, 40);
                  endcase
               end
            end
         end
         req_push          <= holding;
         req_type          <= cur.kind;
         req_note_slot     <= cur.slot;
         req_note_freq     <= cur.freq;
         req_note_ticks    <= cur.ticks;
         req_melody_length <= cur.len;
      end
   end

   // ---------------- result monitor ----------------
   int                pop_cycle = 0;
   int                pop_mode = 0;
   speaker_state_type want;

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_speaker.size() == 0) begin
            note_mismatch("item with none expected, divisor", rsp_tone_divisor, 0);
         end else begin
            want = expected_speaker.pop_front();
            if (rsp_speaker_on !== want.speaker_on)
               note_mismatch("speaker_on", rsp_speaker_on, want.speaker_on);
            if (rsp_tone_divisor !== want.divisor)
               note_mismatch("tone_divisor", rsp_tone_divisor, want.divisor);
            if (rsp_melody_playing !== want.playing)
               note_mismatch("melody_playing", rsp_melody_playing, want.playing);
            if (rsp_beep_active !== want.beeping)
               note_mismatch("beep_active", rsp_beep_active, want.beeping);
         end
      end
      pop_cycle++;
      if (pop_cycle % 200 == 0)
         pop_mode = $urandom_range(0, 3);
      case (pop_mode)
         0:       rsp_pop <= 1'b1;
         1:       rsp_pop <= $urandom_range(0, 1);
         2:       rsp_pop <= (pop_cycle % 7) < 3;
         default: rsp_pop <= (pop_cycle % 40) >= 30;   // long stalls
      endcase
   end

   // ---------------- test sequence ----------------
   logic [7:0]  len_cfgs  [PHASES];
   logic [14:0] freq_cfgs [PHASES];

   initial begin
      int phase;
      int goal;
      int s;

      beep_len_cfg  = tms_pkg::BEEP_LENGTH_RESET;
      beep_freq_cfg = tms_pkg::BEEP_FREQ_RESET;
      cur_note = 0;
      melody_notes = 0;
      ticks_to_go = 0;
      melody_on = 1'b0;
      beep_left = 0;
      gate = 1'b0;
      divisor = '0;
      mismatch_count = 0;
      items_made = 0;
      cur = '{tms_pkg::REQ_UNUSED, 6'd0, 15'd0, 16'd0, 7'd0};
      foreach (note_freq_mem[i]) begin
         note_freq_mem[i]  = 0;
         note_ticks_mem[i] = 0;
         slot_written[i]   = 1'b0;
      end

      len_cfgs  = '{8'd0, 8'd1, 8'd255, 8'd3, 8'($urandom_range(1, 8)), 8'($urandom)};
      freq_cfgs = '{15'd1000, 15'd1, 15'h7FFF, 15'd0, 15'd20000, 15'($urandom)};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: default beep config
      queue_req(tms_pkg::REQ_WRITE, 6'd0, 15'd440, 16'd1, 7'd0);
      queue_req(tms_pkg::REQ_WRITE, 6'd1, 15'd0, 16'd0, 7'h7F);      // rest
      queue_req(tms_pkg::REQ_WRITE, 6'd2, 15'd1, 16'd0, 7'd0);       // divisor wraps
      queue_req(tms_pkg::REQ_WRITE, 6'd3, 15'h7FFF, 16'd0, 7'd0);
      queue_req(tms_pkg::REQ_WRITE, 6'd63, 15'd20000, 16'hFFFF, 7'd0);
      queue_req(tms_pkg::REQ_START, 6'h3F, 15'h7FFF, 16'hFFFF, 7'd4);
      repeat (2) queue_req(tms_pkg::REQ_TICK, 6'd0, 15'd0, 16'd0, 7'd0);
      queue_req(tms_pkg::REQ_BEEP, 6'd0, 15'd0, 16'd0, 7'd0);        // beep over a rest
      repeat (3) queue_req(tms_pkg::REQ_TICK, 6'd0, 15'd0, 16'd0, 7'd0);
      repeat (3) queue_req(tms_pkg::REQ_TICK, 6'h3F, 15'h7FFF, 16'hFFFF, 7'h7F);
      queue_req(tms_pkg::REQ_TONE, 6'd0, 15'd0, 16'd0, 7'd0);        // zero freq, no change
      queue_req(tms_pkg::REQ_TONE, 6'd0, 15'd1, 16'd0, 7'd0);
      queue_req(tms_pkg::REQ_SILENCE, 6'd0, 15'd0, 16'd0, 7'd0);
      queue_req(tms_pkg::REQ_TONE, 6'd0, 15'h7FFF, 16'd0, 7'd0);
      queue_req(tms_pkg::REQ_START, 6'd0, 15'd0, 16'd0, 7'd0);       // zero length ignored
      queue_req(tms_pkg::REQ_STOP, 6'd0, 15'd0, 16'd0, 7'd0);
      queue_req(tms_pkg::REQ_BEEP, 6'd0, 15'd0, 16'd0, 7'd0);
      queue_req(tms_pkg::REQ_STOP, 6'd0, 15'd0, 16'd0, 7'd0);        // beep keeps counting
      repeat (3) queue_req(tms_pkg::REQ_TICK, 6'd0, 15'd0, 16'd0, 7'd0);
      queue_req(tms_pkg::REQ_UNUSED, 6'h2A, 15'h5555, 16'hA5A5, 7'h55);
      wait_idle();

      goal = 0;
      for (phase = 0; phase < PHASES; phase++) begin
         write_csr(tms_pkg::CSR_BEEP_LENGTH, {7'($urandom), len_cfgs[phase]});
         write_csr(tms_pkg::CSR_BEEP_FREQ, freq_cfgs[phase]);
         goal += RAND_ITEMS / PHASES;
         if (phase == 0) begin
            // fill the whole table so any melody length is legal afterwards
            for (s = 0; s < NOTE_SLOTS; s++)
               queue_req(tms_pkg::REQ_WRITE, 6'(s), rand_freq(),
                         16'($urandom_range(0, 3)), 7'($urandom));
         end
         while (items_made < goal + 25) begin
            if ($urandom_range(0, 3) != 0)
               queue_melody_run();
            else
               repeat ($urandom_range(1, 6)) queue_op(3'($urandom_range(0, 7)));
         end
         wait_idle();
      end

      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_speaker.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
